[rtl/core/rmms_pkg.sv]
// ---------------------------------------------------------------------------
// rmms_pkg
// Shared widths and types of the running min/max/mean statistics core.
// ---------------------------------------------------------------------------
package rmms_pkg;

  // Width of every result field on the output stream
  localparam int FIELD_WIDTH = 32;

  // Sample counter width; the counter saturates at all ones
  localparam int COUNT_WIDTH = 32;

  typedef logic [COUNT_WIDTH-1:0] count_t;

endpackage

[rtl/core/rmms_div.sv]
// ---------------------------------------------------------------------------
// rmms_div
// Bit-serial restoring divider: one quotient bit per cycle. The quotient is
// known to fit in QUOT_WIDTH bits, so the upper COUNT_WIDTH bits of the
// dividend are already a valid partial remainder.
// ---------------------------------------------------------------------------
module rmms_div #(
  parameter int QUOT_WIDTH = 32
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  logic [QUOT_WIDTH+rmms_pkg::COUNT_WIDTH-1:0] dividend,
  input  rmms_pkg::count_t                          divisor,
  output logic                                      done,
  output logic [QUOT_WIDTH-1:0]                     quotient
);

  localparam int CW   = rmms_pkg::COUNT_WIDTH;
  localparam int CNTW = $clog2(QUOT_WIDTH + 1);

  logic                  busy;
  logic [CNTW-1:0]       steps;
  logic [CW-1:0]         rem;
  logic [QUOT_WIDTH-1:0] shreg;
  rmms_pkg::count_t      dvsr;

  logic [CW:0]           trial;
  logic [CW:0]           diff;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem, shreg[QUOT_WIDTH-1]};
    diff  = trial - {1'b0, dvsr};
  end

  // Control: step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNTW'(QUOT_WIDTH);
      end else if (busy) begin
        steps <= steps - CNTW'(1);
        if (steps == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= dividend[QUOT_WIDTH+CW-1:QUOT_WIDTH];
      shreg <= dividend[QUOT_WIDTH-1:0];
      dvsr  <= divisor;
    end else if (busy) begin
      if (!diff[CW]) begin
        rem <= diff[CW-1:0];
      end else begin
        rem <= trial[CW-1:0];
      end
      shreg <= {shreg[QUOT_WIDTH-2:0], ~diff[CW]};
    end
  end

  assign quotient = shreg;

endmodule

[rtl/core/running_min_max_mean_stats_core.sv]
// ---------------------------------------------------------------------------
// running_min_max_mean_stats_core
// Running maximum, minimum, mean and count over a stream of operand pairs.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: one transaction carries sample_a and sample_b.
//   Output stream m_axis_*: one transaction per input with both maxima,
//   both minima, both truncated means, the sample count and, in tuser, a
//   flag set when the sample was dropped because the count is saturated.
//   Only the low OPERAND_WIDTH bits of each operand are used.
// Timing:
//   A sample is taken and the statistics are updated in the same cycle,
//   then two bit-serial dividers (one per operand, shared count as divisor)
//   produce the means at one quotient bit per cycle. The sequencer steps
//   through IDLE, START, DIV and OUT, and the result enters the output
//   register as OUT is left. The next sample is taken the cycle after the
//   result enters the output register, so no new sample is accepted while
//   an item is still in progress.
// Reset:
//   rst clears maxima, sums and count to zero and minima to all ones.
// Stall:
//   A result held by a stalled receiver keeps the block from finishing the
//   next item; no result is lost or repeated.
// ---------------------------------------------------------------------------
module running_min_max_mean_stats_core #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  // sample_a [31:0], sample_b [63:32]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,
  // largest_a [31:0], largest_b [63:32], smallest_a [95:64],
  // smallest_b [127:96], mean_a [159:128], mean_b [191:160],
  // sample_count [223:192]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [223:0] m_axis_tdata,
  // count_saturated [0]
  output logic [0:0]   m_axis_tuser
);

  localparam int FW = rmms_pkg::FIELD_WIDTH;
  localparam int CW = rmms_pkg::COUNT_WIDTH;
  localparam int TW = OPERAND_WIDTH + CW;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [OPERAND_WIDTH-1:0] max_a, max_b, min_a, min_b;
  logic [TW-1:0]            total_a, total_b;
  rmms_pkg::count_t         count;
  logic                     dropped;

  logic [OPERAND_WIDTH-1:0] in_a, in_b;
  logic                     in_accept;
  logic                     out_free;
  logic                     div_start;
  logic                     div_done_a, div_done_b;
  logic [OPERAND_WIDTH-1:0] quot_a, quot_b;

  assign in_a      = s_axis_tdata[OPERAND_WIDTH-1:0];
  assign in_b      = s_axis_tdata[32+OPERAND_WIDTH-1:32];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign div_start = (state == ST_START);

  assign s_axis_tready = (state == ST_IDLE);

  // Sequencer; both dividers run in lockstep
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_START;
      end
      ST_START: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done_a && div_done_b) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Running statistics, updated on each accepted transaction unless the count is saturated
  always_ff @(posedge clk) begin
    if (rst) begin
      max_a   <= '0;
      max_b   <= '0;
      min_a   <= '1;
      min_b   <= '1;
      total_a <= '0;
      total_b <= '0;
      count   <= '0;
      dropped <= 1'b0;
    end else if (in_accept) begin
      if (count == '1) begin
        dropped <= 1'b1;
      end else begin
        dropped <= 1'b0;
        if (in_a > max_a) max_a <= in_a;
        if (in_b > max_b) max_b <= in_b;
        if (in_a < min_a) min_a <= in_a;
        if (in_b < min_b) min_b <= in_b;
        total_a <= total_a + TW'(in_a);
        total_b <= total_b + TW'(in_b);
        count   <= count + CW'(1);
      end
    end
  end

  // Mean dividers, one per operand
  rmms_div #(
    .QUOT_WIDTH (OPERAND_WIDTH)
  ) u_div_a (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_a),
    .divisor  (count),
    .done     (div_done_a),
    .quotient (quot_a)
  );

  rmms_div #(
    .QUOT_WIDTH (OPERAND_WIDTH)
  ) u_div_b (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_b),
    .divisor  (count),
    .done     (div_done_b),
    .quotient (quot_b)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_axis_tdata <= {FW'(count), FW'(quot_b), FW'(quot_a),
                       FW'(min_b), FW'(min_a), FW'(max_b), FW'(max_a)};
      m_axis_tuser <= dropped;
    end
  end

endmodule
